/* hw/rtl/dwmu_pkg.sv */
// Package: types and constants shared by the dense weight momentum update core.
`default_nettype none
package dwmu_pkg;

    localparam int ACC_W   = 48;
    localparam int DIVS_W  = 16;
    localparam int WORD_W  = 32;
    localparam int SMPL_W  = 16;
    localparam int PROD_W  = 64;

    // 0.9 in Q0.30
    localparam logic [29:0] DECAY_Q30 = 30'd966367642;

    localparam logic [2:0] ADDR_RATE = 3'd0;

    typedef struct packed {
        logic signed [SMPL_W-1:0] activation;
        logic signed [SMPL_W-1:0] out_grad;
        logic signed [WORD_W-1:0] weight_in;
        logic signed [WORD_W-1:0] moment_in;
        logic                     last_sample;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_weight;
        logic signed [WORD_W-1:0] new_moment;
    } out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_ACC,
        ST_SCALE,
        ST_DIV,
        ST_MOM,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

/* hw/rtl/dense_weight_momentum_update_core.sv */
// Top level: sequencer, accumulator and result stage of the momentum update core.
// Non-last sample: each beat is accepted, multiplied and accumulated; in_stall high meanwhile.
// Last sample: scale, the 48-step divider, momentum and output steps follow before the result beat.
// The shared multiplier serves both the sample product and the 0.9 momentum scale.
// Output register lets a finished result wait while the next beat is taken.
// rst_n async active low: accumulator 0, rate register 1, no result pending.
`default_nettype none
module dense_weight_momentum_update_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire dwmu_pkg::in_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output dwmu_pkg::out_t                   out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int ACC_W  = dwmu_pkg::ACC_W;
    localparam int WORD_W = dwmu_pkg::WORD_W;
    localparam int SMPL_W = dwmu_pkg::SMPL_W;
    localparam int PROD_W = dwmu_pkg::PROD_W;
    localparam int DIVS_W = dwmu_pkg::DIVS_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [49:0] W_MAX50 = 50'sd2147483647;
    localparam logic signed [49:0] W_MIN50 = -50'sd2147483648;
    localparam logic signed [33:0] W_MAX34 = 34'sd2147483647;
    localparam logic signed [33:0] W_MIN34 = -34'sd2147483648;

    dwmu_pkg::state_t state_reg, state_next;
    dwmu_pkg::in_t    in_reg;
    dwmu_pkg::out_t   out_reg, out_next;
    dwmu_pkg::div_stat_t div_stat;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  sum_reg, sum_next;
    logic                     neg_reg, neg_next;
    logic signed [32:0]       scaled_reg, scaled_next;
    logic signed [ACC_W:0]    quot_reg, quot_next;
    logic signed [WORD_W-1:0] mom_reg, mom_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DIVS_W-1:0]        rate_reg;

    logic signed [WORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [PROD_W-1:0] rounded;
    logic signed [49:0]       mom_sum;
    logic signed [33:0]       wt_diff;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         quotient;
    logic [DIVS_W-1:0]        divisor;
    logic                     div_start;
    logic                     load;
    logic                     cfg_wr;

    dwmu_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    dwmu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (divisor),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dwmu_pkg::ADDR_RATE[2]) ? {16'd0, rate_reg} : 32'd0;
    assign divisor = (rate_reg == '0) ? DIVS_W'(1) : rate_reg;
    assign mag = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : sum_reg;

    assign in_stall  = state_reg != dwmu_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        scaled_next    = scaled_reg;
        quot_next      = quot_reg;
        mom_next       = mom_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        load           = 1'b0;
        mul_a          = in_reg.moment_in;
        mul_b          = {2'b00, dwmu_pkg::DECAY_Q30};
        acc_sum        = {acc_reg[ACC_W-1], acc_reg} + {prod[ACC_W-1], prod[ACC_W-1:0]};
        rounded        = prod + PROD_W'(64'sd536870912);
        mom_sum        = 50'(scaled_reg) + 50'(quot_reg);
        wt_diff        = 34'(in_reg.weight_in) - 34'(mom_reg);

        case (state_reg)
            dwmu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dwmu_pkg::ST_MULT;
                end
            end
            dwmu_pkg::ST_MULT:
            begin
                mul_a      = {{(WORD_W-SMPL_W){in_reg.activation[SMPL_W-1]}},
                              in_reg.activation};
                mul_b      = {{(WORD_W-SMPL_W){in_reg.out_grad[SMPL_W-1]}},
                              in_reg.out_grad};
                state_next = dwmu_pkg::ST_ACC;
            end
            dwmu_pkg::ST_ACC:
            begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                begin
                    sum_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
                end
                else
                begin
                    sum_next = acc_sum[ACC_W-1:0];
                end
                if (in_reg.last_sample)
                begin
                    acc_next   = '0;
                    state_next = dwmu_pkg::ST_SCALE;
                end
                else
                begin
                    acc_next   = sum_next;
                    state_next = dwmu_pkg::ST_IDLE;
                end
            end
            dwmu_pkg::ST_SCALE:
            begin
                scaled_next = rounded[62:30];
                neg_next    = sum_reg[ACC_W-1];
                div_start   = 1'b1;
                state_next  = dwmu_pkg::ST_DIV;
            end
            dwmu_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    quot_next  = neg_reg ? -$signed({1'b0, quotient})
                                         : $signed({1'b0, quotient});
                    state_next = dwmu_pkg::ST_MOM;
                end
            end
            dwmu_pkg::ST_MOM:
            begin
                if (mom_sum > W_MAX50)
                begin
                    mom_next = W_MAX50[WORD_W-1:0];
                end
                else if (mom_sum < W_MIN50)
                begin
                    mom_next = W_MIN50[WORD_W-1:0];
                end
                else
                begin
                    mom_next = mom_sum[WORD_W-1:0];
                end
                state_next = dwmu_pkg::ST_OUT;
            end
            dwmu_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load                = 1'b1;
                    out_next.new_moment = mom_reg;
                    if (wt_diff > W_MAX34)
                    begin
                        out_next.new_weight = W_MAX34[WORD_W-1:0];
                    end
                    else if (wt_diff < W_MIN34)
                    begin
                        out_next.new_weight = W_MIN34[WORD_W-1:0];
                    end
                    else
                    begin
                        out_next.new_weight = wt_diff[WORD_W-1:0];
                    end
                    state_next = dwmu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dwmu_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dwmu_pkg::ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= DIVS_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && paddr[2] == dwmu_pkg::ADDR_RATE[2])
            begin
                rate_reg <= pwdata[DIVS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dwmu_pkg::ST_IDLE && in_valid)
        begin
            in_reg <= in_data;
        end
        sum_reg    <= sum_next;
        neg_reg    <= neg_next;
        scaled_reg <= scaled_next;
        quot_reg   <= quot_next;
        mom_reg    <= mom_next;
        out_reg    <= out_next;
    end

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dwmu_pkg::ST_OUT))
        else $error("result appeared outside the output step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == dwmu_pkg::ST_DIV)
        else $error("divider finished while sequencer not waiting");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dwmu_pkg::ST_SCALE |-> acc_reg == '0)
        else $error("accumulator not cleared after last sample");

    a_no_div_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire

/* hw/rtl/dwmu_mul.sv */
// Shared signed 32x32 multiplier with registered product.
`default_nettype none
module dwmu_mul (
    input  wire logic                                  clk,
    input  wire logic signed [dwmu_pkg::WORD_W-1:0]    op_a,
    input  wire logic signed [dwmu_pkg::WORD_W-1:0]    op_b,
    output logic signed      [dwmu_pkg::PROD_W-1:0]    prod
);

    logic signed [dwmu_pkg::PROD_W-1:0] prod_reg;
    logic signed [dwmu_pkg::PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = dwmu_pkg::PROD_W'(op_a) * dwmu_pkg::PROD_W'(op_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* hw/rtl/dwmu_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module dwmu_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [dwmu_pkg::ACC_W-1:0]       dividend,
    input  wire logic [dwmu_pkg::DIVS_W-1:0]      divisor,
    output logic      [dwmu_pkg::ACC_W-1:0]       quotient,
    output dwmu_pkg::div_stat_t                   stat
);

    localparam int STEPS = dwmu_pkg::ACC_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [dwmu_pkg::ACC_W-1:0]  dvd_reg, dvd_next;
    logic [dwmu_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [dwmu_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [dwmu_pkg::DIVS_W:0]   shifted;
    logic                        ge;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[dwmu_pkg::ACC_W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[dwmu_pkg::ACC_W-2:0], ge};
            rem_next = ge ? dwmu_pkg::DIVS_W'(shifted - {1'b0, dvs_reg})
                          : shifted[dwmu_pkg::DIVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire
